### sv/dqir_pkg.sv
// Package with the word types, operation codes and sizes of the double-ended queue.
`default_nettype none
package dqir_pkg;

    // Store sizes
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Operation codes carried in the func field
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_REMOVE     = 3'd4,
        FN_PEEK_FRONT = 3'd5,
        FN_COUNT      = 3'd6
    } func_t;

    // Status codes returned with every result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Request word
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] entry_data;
        logic [3:0]  entry_index;
    } req_t;

    // Result word
    typedef struct packed {
        logic [31:0] out_data;
        logic [4:0]  entry_count;
        logic [1:0]  status;
    } rsp_t;

    // Control from the decoder to the store
    typedef struct packed {
        logic             load_front;
        logic             load_back;
        logic             take;
        logic             read_out;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count_next;
        status_t          status;
    } ctrl_t;

endpackage
`default_nettype wire

### sv/dqir_decode.sv
// Operation decoder: checks the request against the occupancy and plans the update.
`default_nettype none
module dqir_decode (
    input  wire  dqir_pkg::req_t                req,
    input  wire  logic [dqir_pkg::CNT_W-1:0]    occupancy,
    output dqir_pkg::ctrl_t                     ctrl
);

    logic empty;
    logic full;
    logic [dqir_pkg::CNT_W-1:0] idx_ext;

    assign empty   = (occupancy == '0);
    assign full    = (occupancy >= dqir_pkg::CNT_W'(dqir_pkg::DEPTH));
    assign idx_ext = dqir_pkg::CNT_W'(req.entry_index);

    // Decide the operation, its status and the entry count that follows it.
    always_comb
    begin
        ctrl            = '0;
        ctrl.status     = dqir_pkg::ST_OK;
        ctrl.count_next = occupancy;
        case (req.func)
            dqir_pkg::FN_PUSH_FRONT,
            dqir_pkg::FN_PUSH_BACK:
            begin
                if (full)
                begin
                    ctrl.status = dqir_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.load_front = (req.func == dqir_pkg::FN_PUSH_FRONT);
                    ctrl.load_back  = (req.func == dqir_pkg::FN_PUSH_BACK);
                    ctrl.count_next = occupancy + 1'b1;
                end
            end
            dqir_pkg::FN_POP_FRONT,
            dqir_pkg::FN_POP_BACK:
            begin
                if (empty)
                begin
                    ctrl.status = dqir_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.take       = 1'b1;
                    ctrl.read_out   = 1'b1;
                    ctrl.count_next = occupancy - 1'b1;
                    if (req.func == dqir_pkg::FN_POP_BACK)
                    begin
                        ctrl.pos = dqir_pkg::IDX_W'(occupancy - 1'b1);
                    end
                end
            end
            dqir_pkg::FN_REMOVE:
            begin
                if (empty)
                begin
                    ctrl.status = dqir_pkg::ST_EMPTY;
                end
                else if (idx_ext >= occupancy)
                begin
                    ctrl.status = dqir_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.take       = 1'b1;
                    ctrl.read_out   = 1'b1;
                    ctrl.pos        = dqir_pkg::IDX_W'(req.entry_index);
                    ctrl.count_next = occupancy - 1'b1;
                end
            end
            dqir_pkg::FN_PEEK_FRONT:
            begin
                if (empty)
                begin
                    ctrl.status = dqir_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.read_out = 1'b1;
                end
            end
            default:
            begin
                // Count and the unused code leave everything as it is.
                ctrl.status = dqir_pkg::ST_OK;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/dqir_store.sv
// Entry store: slot registers that load or shift in parallel, plus the occupancy register.
`default_nettype none
module dqir_store (
    input  wire  logic                                clk,
    input  wire  logic                                rst_n,
    input  wire  logic                                enable,
    input  wire  dqir_pkg::ctrl_t                     ctrl,
    input  wire  logic [dqir_pkg::DATA_WIDTH-1:0]     wr_data,
    output logic [dqir_pkg::CNT_W-1:0]                occupancy,
    output logic [dqir_pkg::DATA_WIDTH-1:0]           rd_data
);

    logic [dqir_pkg::DATA_WIDTH-1:0] slot_reg  [dqir_pkg::DEPTH];
    logic [dqir_pkg::DATA_WIDTH-1:0] slot_next [dqir_pkg::DEPTH];
    logic [dqir_pkg::CNT_W-1:0]      occ_reg;

    assign occupancy = occ_reg;

    // The one read port gives the entry at the chosen position.
    assign rd_data = slot_reg[ctrl.pos];

    // Each slot picks its neighbour, the new word or itself from a position compare.
    always_comb
    begin
        for (int i = 0; i < dqir_pkg::DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (ctrl.load_front)
            begin
                if (i == 0)
                begin
                    slot_next[i] = wr_data;
                end
                else
                begin
                    slot_next[i] = slot_reg[i-1];
                end
            end
            else if (ctrl.load_back)
            begin
                if (dqir_pkg::CNT_W'(i) == occ_reg)
                begin
                    slot_next[i] = wr_data;
                end
            end
            else if (ctrl.take)
            begin
                if ((i < dqir_pkg::DEPTH - 1) && (dqir_pkg::IDX_W'(i) >= ctrl.pos))
                begin
                    slot_next[i] = slot_reg[(i + 1) % dqir_pkg::DEPTH];
                end
            end
        end
    end

    // Slot payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int i = 0; i < dqir_pkg::DEPTH; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // Occupancy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (enable)
        begin
            occ_reg <= ctrl.count_next;
        end
    end

endmodule
`default_nettype wire

### sv/deque_with_indexed_removal_core.sv
// Top level of the double-ended queue with removal at a given position.
// The request channel (req_valid, req_ready, req) takes one word per operation:
// push front or back, pop front or back, remove at entry_index, peek front or count.
// The response channel (rsp_valid, rsp_ready, rsp) returns exactly one word per
// request, in request order, with the removed or peeked entry, the entry count
// after the operation and a status (ok, empty, full, index out of range).
// A failed operation leaves the stored entries untouched.
// A request is registered on acceptance; the decoder and the parallel slot update then
// act on it from the request register, and the result is registered in the response
// register once that register is free or being emptied, which raises rsp_valid.
// Throughput is one operation per cycle while rsp_ready stays high: the slots load
// or shift all at once, and the response register lets a new request be accepted
// while a result still waits.
// If the receiver stalls, the response register holds its word, the request
// register fills, and req_ready drops until rsp_ready returns.
// Reset empties the queue and clears both valid flags; no clearing pass is run.
`default_nettype none
module deque_with_indexed_removal_core (
    input  wire  logic            clk,
    input  wire  logic            rst_n,
    input  wire  logic            req_valid,
    output logic                  req_ready,
    input  wire  dqir_pkg::req_t  req,
    output logic                  rsp_valid,
    input  wire  logic            rsp_ready,
    output dqir_pkg::rsp_t        rsp
);

    dqir_pkg::req_t   req_reg;
    logic             req_valid_reg;
    dqir_pkg::rsp_t   rsp_reg;
    dqir_pkg::rsp_t   rsp_next;
    logic             rsp_valid_reg;
    logic             advance;
    logic             fire;
    dqir_pkg::ctrl_t  ctrl;
    logic [dqir_pkg::CNT_W-1:0]      occupancy;
    logic [dqir_pkg::DATA_WIDTH-1:0] rd_data;

    // The held request moves on when the response register is free or being emptied.
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid_reg && advance;
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req;
        end
    end

    dqir_decode u_decode (
        .req       (req_reg),
        .occupancy (occupancy),
        .ctrl      (ctrl)
    );

    dqir_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (fire),
        .ctrl      (ctrl),
        .wr_data   (req_reg.entry_data),
        .occupancy (occupancy),
        .rd_data   (rd_data)
    );

    // Assemble the result word.
    always_comb
    begin
        rsp_next.out_data    = ctrl.read_out ? rd_data : '0;
        rsp_next.entry_count = ctrl.count_next;
        rsp_next.status      = ctrl.status;
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
`default_nettype wire
